/* rtl/s512pad_pkg.sv */
package s512pad_pkg;

  // input operation codes
  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam int unsigned BLOCK_BYTES  = 128;
  localparam int unsigned WORD_BYTES   = 8;
  localparam int unsigned BLOCK_WORDS  = BLOCK_BYTES / WORD_BYTES;
  localparam int unsigned FILL_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned WIDX_W       = $clog2(BLOCK_WORDS);
  localparam int unsigned LANE_W       = $clog2(WORD_BYTES);
  localparam int unsigned COUNT_W      = 61;

  localparam logic [7:0]        PAD_BYTE  = 8'h80;
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(BLOCK_WORDS - 1);
  // fill level at or past which the length field no longer fits after the 0x80 byte
  localparam logic [FILL_W-1:0] LEN_OFFSET = FILL_W'(112);

  // where an emitted word comes from
  typedef enum logic [1:0] {
    SRC_MEM,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } src_t;

endpackage

/* rtl/sha512_message_padder_top.sv */
// sha512 message padder: front end of a sha-512/384 engine
//
// input channel (in_valid / in_stall): one item per transfer. in_operation
// selects a message byte (OP_DATA, in_data_byte) or the end of the message
// (OP_FINISH). bytes collect into a 128-byte block kept as 16 words of 64 bits
// in a single-port memory with a registered read.
// result channel (out_valid / out_stall): one 64-bit big-endian word per
// transfer, with its index in the block and first / last flags.
// a data byte does not raise in_stall unless it completes a block; a finish item
// emits one block (two when the 0x80 byte lands at offset 112 or above).
// while a block goes out, in_stall stays high.
// each word passes through two states: S_READ reads the memory, S_SHOW
// shows it on the output. the first word is offered after the S_READ state
// that follows the transfer that triggers the block; the next word is read
// only after the shown one is taken.
// out_stall holds the shown word and all its flags until it is taken.
// reset clears the fill level, the byte count and the state machine and
// arms the first-block flag; the memory needs no clearing because every word
// read out is written earlier in the same block or replaced by padding.
module sha512_message_padder_top
  import s512pad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_block_word,
  output logic [3:0]  out_word_index,
  output logic        out_first_block,
  output logic        out_last_of_block,
  output logic        out_last_of_message
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } state_t;

  state_t state_r;

  // block memory, one 64-bit word per entry
  logic [63:0] mem [BLOCK_WORDS];
  logic        mem_we;
  logic [63:0] rd_r;

  // control state
  logic [FILL_W-1:0]  fill_r;
  logic [COUNT_W-1:0] count_r;
  logic               first_r;
  logic [WIDX_W-1:0]  widx_r;
  logic               pad_mode_r;   // emitting padded blocks
  logic               two_r;        // first of two padded blocks still to go
  logic               after_r;      // second padded block: all but length is zero
  logic [WIDX_W-1:0]  pad_idx_r;    // word holding the 0x80 byte
  logic               out_valid_r;
  src_t               src_r;
  src_t               src_nxt;

  // payload
  logic [63:0] acc_r;       // word being assembled
  logic [63:0] acc_nxt;
  logic [63:0] pad_word_r;
  logic [63:0] pad_word_nxt;
  logic [63:0] bit_len_r;

  logic [LANE_W-1:0] lane;
  logic              in_xfer;
  logic              out_xfer;

  assign lane     = fill_r[LANE_W-1:0];
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign mem_we   = in_xfer && (in_operation == OP_DATA) && (lane == LANE_W'(WORD_BYTES - 1));

  // byte lane insert, lane 0 is the most significant byte
  always_comb begin
    acc_nxt = acc_r;
    for (int l = 0; l < WORD_BYTES; l++) begin
      if (LANE_W'(l) == lane) begin
        acc_nxt[(WORD_BYTES-1-l)*8 +: 8] = in_data_byte;
      end
    end
  end

  // padded word: bytes so far, then 0x80, then zeros
  always_comb begin
    pad_word_nxt = '0;
    for (int l = 0; l < WORD_BYTES; l++) begin
      if (LANE_W'(l) < lane) begin
        pad_word_nxt[(WORD_BYTES-1-l)*8 +: 8] = acc_r[(WORD_BYTES-1-l)*8 +: 8];
      end else if (LANE_W'(l) == lane) begin
        pad_word_nxt[(WORD_BYTES-1-l)*8 +: 8] = PAD_BYTE;
      end
    end
  end

  // source of the word about to be read
  always_comb begin
    if (!pad_mode_r) begin
      src_nxt = SRC_MEM;
    end else if (!two_r && (widx_r == LAST_WORD)) begin
      src_nxt = SRC_LEN;
    end else if (after_r) begin
      src_nxt = SRC_ZERO;
    end else if (widx_r < pad_idx_r) begin
      src_nxt = SRC_MEM;
    end else if (widx_r == pad_idx_r) begin
      src_nxt = SRC_PAD;
    end else begin
      src_nxt = SRC_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[FILL_W-1:LANE_W]] <= acc_nxt;
    end
    if (state_r == S_READ) begin
      rd_r <= mem[widx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (in_operation == OP_DATA) begin
        acc_r <= acc_nxt;
      end else begin
        pad_word_r <= pad_word_nxt;
        bit_len_r  <= {count_r, 3'b000};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      count_r     <= '0;
      first_r     <= 1'b1;
      widx_r      <= '0;
      pad_mode_r  <= 1'b0;
      two_r       <= 1'b0;
      after_r     <= 1'b0;
      pad_idx_r   <= '0;
      out_valid_r <= 1'b0;
      src_r       <= SRC_MEM;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            widx_r <= '0;
            if (in_operation == OP_DATA) begin
              fill_r  <= fill_r + FILL_W'(1);
              count_r <= count_r + COUNT_W'(1);
              if (fill_r == FILL_W'(BLOCK_BYTES - 1)) begin
                pad_mode_r <= 1'b0;
                state_r    <= S_READ;
              end
            end else begin
              fill_r     <= '0;
              count_r    <= '0;
              pad_mode_r <= 1'b1;
              two_r      <= (fill_r >= LEN_OFFSET);
              after_r    <= 1'b0;
              pad_idx_r  <= fill_r[FILL_W-1:LANE_W];
              state_r    <= S_READ;
            end
          end
        end
        S_READ: begin
          src_r       <= src_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_SHOW;
        end
        S_SHOW: begin
          if (out_xfer) begin
            out_valid_r <= 1'b0;
            if (widx_r == LAST_WORD) begin
              widx_r <= '0;
              if (pad_mode_r && two_r) begin
                // on to the block that carries only the length
                two_r   <= 1'b0;
                after_r <= 1'b1;
                first_r <= 1'b0;
                state_r <= S_READ;
              end else if (pad_mode_r) begin
                pad_mode_r <= 1'b0;
                first_r    <= 1'b1;
                state_r    <= S_IDLE;
              end else begin
                first_r <= 1'b0;
                state_r <= S_IDLE;
              end
            end else begin
              widx_r  <= widx_r + WIDX_W'(1);
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    case (src_r)
      SRC_MEM:  out_block_word = rd_r;
      SRC_PAD:  out_block_word = pad_word_r;
      SRC_LEN:  out_block_word = bit_len_r;
      default:  out_block_word = '0;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_word_index      = widx_r;
  assign out_first_block     = first_r;
  assign out_last_of_block   = (widx_r == LAST_WORD);
  assign out_last_of_message = pad_mode_r && !two_r && (widx_r == LAST_WORD);

  // no input is taken while a word is on offer
  a_no_input_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a word is on offer");

  // words of a block go out in order
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_of_block) |=>
      (out_word_index == $past(out_word_index) + 4'd1))
    else $error("word index did not advance");

  // the length word closes the message and re-arms the first-block flag
  a_first_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_of_message) |=> (out_first_block && !in_stall))
    else $error("first-block flag not re-armed after message");

  // a finish always leads into a padded emission
  a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_operation == OP_FINISH)) |=> (in_stall && pad_mode_r))
    else $error("finish did not start padding");

endmodule
